[hw/rtl/bvfg_pkg.sv]
// Shared widths, types, curve table and state encoding for the battery fuel gauge.
package bvfg_pkg;

  localparam int SAMPLE_W       = 13;
  localparam int PCT_W          = 7;
  localparam int ICON_W         = 3;
  localparam int WINDOW_LEN_DEF = 5;
  localparam int CURVE_POINTS   = 14;
  localparam int CURVE_IDX_W    = $clog2(CURVE_POINTS);
  localparam int PROD_W         = SAMPLE_W + PCT_W;
  localparam int DIV_CNT_W      = $clog2(PROD_W);
  localparam int MUL_CNT_W      = $clog2(PCT_W);

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [PCT_W-1:0] ICON_T4 = 7'd95;
  localparam logic [PCT_W-1:0] ICON_T3 = 7'd65;
  localparam logic [PCT_W-1:0] ICON_T2 = 7'd35;
  localparam logic [PCT_W-1:0] ICON_T1 = 7'd5;

  typedef logic [SAMPLE_W-1:0]    mv_t;
  typedef logic [PCT_W-1:0]       pct_t;
  typedef logic [ICON_W-1:0]      icon_t;
  typedef logic [PROD_W-1:0]      prod_t;
  typedef logic [CURVE_IDX_W-1:0] curve_idx_t;

  localparam curve_idx_t CURVE_LAST = curve_idx_t'(CURVE_POINTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_SEARCH,
    ST_MUL,
    ST_SCALE,
    ST_LOAD
  } state_t;

  function automatic mv_t curve_mv(curve_idx_t k);
    mv_t v;
    case (k)
      4'd0:    v = 13'd3450;
      4'd1:    v = 13'd3500;
      4'd2:    v = 13'd3550;
      4'd3:    v = 13'd3600;
      4'd4:    v = 13'd3650;
      4'd5:    v = 13'd3700;
      4'd6:    v = 13'd3750;
      4'd7:    v = 13'd3800;
      4'd8:    v = 13'd3850;
      4'd9:    v = 13'd3900;
      4'd10:   v = 13'd3950;
      4'd11:   v = 13'd4000;
      4'd12:   v = 13'd4100;
      default: v = 13'd4200;
    endcase
    return v;
  endfunction

  function automatic pct_t curve_pct(curve_idx_t k);
    pct_t v;
    case (k)
      4'd0:    v = 7'd0;
      4'd1:    v = 7'd2;
      4'd2:    v = 7'd5;
      4'd3:    v = 7'd9;
      4'd4:    v = 7'd16;
      4'd5:    v = 7'd25;
      4'd6:    v = 7'd36;
      4'd7:    v = 7'd48;
      4'd8:    v = 7'd60;
      4'd9:    v = 7'd68;
      4'd10:   v = 7'd74;
      4'd11:   v = 7'd80;
      4'd12:   v = 7'd92;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

  function automatic icon_t icon_of(pct_t p);
    icon_t v;
    if (p > ICON_T4) begin
      v = 3'd4;
    end else if (p > ICON_T3) begin
      v = 3'd3;
    end else if (p > ICON_T2) begin
      v = 3'd2;
    end else if (p > ICON_T1) begin
      v = 3'd1;
    end else begin
      v = 3'd0;
    end
    return v;
  endfunction

endpackage

[hw/rtl/bvfg_window.sv]
// Sample window shift line with a rotating one-entry-per-cycle summation.
module bvfg_window #(
  parameter int WINDOW_LEN = bvfg_pkg::WINDOW_LEN_DEF,
  localparam int FILL_W = $clog2(WINDOW_LEN + 1),
  localparam int SUM_W = bvfg_pkg::SAMPLE_W + $clog2(WINDOW_LEN)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  bvfg_pkg::mv_t     sample,
  output logic              sum_done,
  output logic [FILL_W-1:0] fill,
  output logic [SUM_W-1:0]  sum
);
  import bvfg_pkg::*;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
  localparam logic [FILL_W-1:0] CNT_LAST  = FILL_W'(WINDOW_LEN - 1);

  mv_t               win [WINDOW_LEN];
  logic              busy;
  logic [FILL_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      busy     <= 1'b0;
      cnt      <= '0;
      sum_done <= 1'b0;
    end else begin
      sum_done <= 1'b0;
      if (take) begin
        busy <= 1'b1;
        cnt  <= '0;
        if (sample != '0 && fill != FILL_FULL) begin
          fill <= fill + 1'b1;
        end
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy     <= 1'b0;
          sum_done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // The newest sample sits at entry zero; a full rotation restores the order.
  always_ff @(posedge clk) begin
    if (take) begin
      sum <= '0;
      if (sample != '0) begin
        win[0] <= sample;
        for (int k = 1; k < WINDOW_LEN; k++) begin
          win[k] <= win[k-1];
        end
      end
    end else if (busy) begin
      sum <= sum + ((cnt < fill) ? SUM_W'(win[0]) : '0);
      for (int k = 0; k < WINDOW_LEN - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[WINDOW_LEN-1] <= win[0];
    end
  end

endmodule

[hw/rtl/bvfg_serdiv.sv]
// Restoring divider that produces one quotient bit per cycle.
module bvfg_serdiv (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bvfg_pkg::prod_t dividend,
  input  bvfg_pkg::mv_t   divisor,
  output logic            done,
  output bvfg_pkg::prod_t quotient
);
  import bvfg_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(PROD_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  mv_t                  rem;
  mv_t                  dvs;
  logic [SAMPLE_W:0]    shifted;
  logic                 ge;

  assign shifted = {rem, quotient[PROD_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? SAMPLE_W'(shifted - {1'b0, dvs}) : shifted[SAMPLE_W-1:0];
      quotient <= {quotient[PROD_W-2:0], ge};
    end
  end

endmodule

[hw/rtl/bvfg_sermul.sv]
// Shift-and-add multiplier that consumes one multiplier bit per cycle.
module bvfg_sermul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bvfg_pkg::mv_t   mcand,
  input  bvfg_pkg::pct_t  mplier,
  output logic            done,
  output bvfg_pkg::prod_t product
);
  import bvfg_pkg::*;

  localparam logic [MUL_CNT_W-1:0] CNT_LAST = MUL_CNT_W'(PCT_W - 1);

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  prod_t                addend;
  pct_t                 bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      product <= '0;
      addend  <= PROD_W'(mcand);
      bits    <= mplier;
    end else if (busy) begin
      if (bits[0]) begin
        product <= product + addend;
      end
      addend <= {addend[PROD_W-2:0], 1'b0};
      bits   <= {1'b0, bits[PCT_W-1:1]};
    end
  end

endmodule

[hw/rtl/battery_voltage_fuel_gauge_core.sv]
// Battery fuel gauge: moving average of voltage samples mapped to a LiPo state of charge.
// One transaction is handled at a time. After it is accepted the window is summed one entry per
// cycle, the mean is formed by a bit-serial divider, the curve segment is found one breakpoint
// per cycle, the offset is scaled by a bit-serial multiplier and divided again by the segment
// width. When no sample has been stored yet the result is loaded straight after the summation,
// and when the mean lies at an end of the curve it is loaded straight after the search. The next
// transaction can be accepted in the cycle after the result is loaded. The divider is used twice,
// for the mean and for the scaling step. The result sits in an output register, so a new
// transaction may be accepted while the previous result still waits to be taken.
module battery_voltage_fuel_gauge_core #(
  parameter int WINDOW_LEN = bvfg_pkg::WINDOW_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bvfg_pkg::mv_t  sample_mv,
  input  bvfg_pkg::pct_t fallback_percent,
  input  logic           charger_present,
  output logic           out_valid,
  input  logic           out_ready,
  output bvfg_pkg::mv_t  avg_mv,
  output bvfg_pkg::pct_t level_percent,
  output bvfg_pkg::icon_t icon_level,
  output logic           charging
);
  import bvfg_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LEN);

  state_t            state;
  state_t            state_next;
  logic              take;
  logic              sum_done;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0]  sum;
  logic              div_start;
  logic              div_done;
  prod_t             div_dividend;
  mv_t               div_divisor;
  prod_t             quotient;
  logic              mul_start;
  logic              mul_done;
  prod_t             product;
  logic              load_out;

  pct_t              fb_q;
  logic              chg_q;
  mv_t               mean;
  pct_t              res_pct;
  curve_idx_t        seg_k;
  curve_idx_t        seg_prev;
  mv_t               dx;
  pct_t              y0;
  logic              clamp_hi;
  logic              clamp_lo;
  logic              seg_hit;
  mv_t               seg_off;
  pct_t              seg_dy;

  assign seg_prev = seg_k - 1'b1;
  assign clamp_hi = mean >= curve_mv(CURVE_LAST);
  assign clamp_lo = mean <= curve_mv('0);
  assign seg_hit  = mean < curve_mv(seg_k);
  assign seg_off  = mean - curve_mv(seg_prev);
  assign seg_dy   = curve_pct(seg_k) - curve_pct(seg_prev);

  assign div_dividend = (state == ST_SUM) ? PROD_W'(sum) : product;
  assign div_divisor  = (state == ST_SUM) ? SAMPLE_W'(fill) : dx;

  bvfg_window #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .sample  (sample_mv),
    .sum_done(sum_done),
    .fill    (fill),
    .sum     (sum)
  );

  bvfg_serdiv u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(quotient)
  );

  bvfg_sermul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (seg_off),
    .mplier (seg_dy),
    .done   (mul_done),
    .product(product)
  );

  always_comb begin
    in_ready  = (state == ST_IDLE);
    take      = in_valid && in_ready;
    div_start = ((state == ST_SUM) && sum_done && (fill != '0)) ||
                ((state == ST_MUL) && mul_done);
    mul_start = (state == ST_SEARCH) && !clamp_hi && !clamp_lo && seg_hit;
    load_out  = (state == ST_LOAD) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_done) begin
          state_next = (fill == '0) ? ST_LOAD : ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (clamp_hi || clamp_lo) begin
          state_next = ST_LOAD;
        end else if (seg_hit) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fb_q  <= fallback_percent;
      chg_q <= charger_present;
    end
    case (state)
      ST_SUM: begin
        if (sum_done && fill == '0) begin
          mean    <= '0;
          res_pct <= (fb_q > PCT_MAX) ? PCT_MAX : fb_q;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean  <= quotient[SAMPLE_W-1:0];
          seg_k <= curve_idx_t'(1);
        end
      end
      ST_SEARCH: begin
        if (clamp_hi) begin
          res_pct <= PCT_MAX;
        end else if (clamp_lo) begin
          res_pct <= '0;
        end else if (seg_hit) begin
          dx <= curve_mv(seg_k) - curve_mv(seg_prev);
          y0 <= curve_pct(seg_prev);
        end else begin
          seg_k <= seg_k + 1'b1;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          res_pct <= y0 + quotient[PCT_W-1:0];
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      avg_mv        <= mean;
      level_percent <= res_pct;
      icon_level    <= icon_of(res_pct);
      charging      <= chg_q;
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the battery voltage fuel gauge core with its own gauge predictor.
module testbench;
  import bvfg_pkg::*;

  localparam int AVG_DEPTH       = WINDOW_LEN_DEF;
  localparam int IDLE_LIMIT      = 5000;
  localparam int HOLD_CYCLES     = 600;
  localparam int RANDOM_READINGS = 1250;
  localparam int SETTLE_CYCLES   = 100;
  localparam int PROBE_COUNT     = 25;

  typedef struct packed {
    mv_t   mv;
    pct_t  pct;
    icon_t icon;
    logic  chg;
  } reading_t;

  typedef struct packed {
    mv_t      mv;
    pct_t     fb;
    logic     chg;
    logic     typed;
    reading_t want;
  } probe_t;

  localparam int unsigned LIPO_MV [CURVE_POINTS] = '{
    3450, 3500, 3550, 3600, 3650, 3700, 3750, 3800, 3850, 3900, 3950, 4000, 4100, 4200
  };
  localparam int unsigned CURVE_SOC [CURVE_POINTS] = '{
    0, 2, 5, 9, 16, 25, 36, 48, 60, 68, 74, 80, 92, 100
  };

  // Rows with typed set carry an expectation written by hand; the rest use the predictor.
  localparam probe_t PROBES [PROBE_COUNT] = '{
    '{13'd0,    7'd0,   1'b0, 1'b1, '{13'd0,    7'd0,   3'd0, 1'b0}},
    '{13'd0,    7'd127, 1'b1, 1'b1, '{13'd0,    7'd100, 3'd4, 1'b1}},
    '{13'd0,    7'd100, 1'b0, 1'b1, '{13'd0,    7'd100, 3'd4, 1'b0}},
    '{13'd0,    7'd96,  1'b1, 1'b1, '{13'd0,    7'd96,  3'd4, 1'b1}},
    '{13'd0,    7'd95,  1'b0, 1'b1, '{13'd0,    7'd95,  3'd3, 1'b0}},
    '{13'd0,    7'd66,  1'b0, 1'b1, '{13'd0,    7'd66,  3'd3, 1'b0}},
    '{13'd0,    7'd65,  1'b1, 1'b1, '{13'd0,    7'd65,  3'd2, 1'b1}},
    '{13'd0,    7'd36,  1'b0, 1'b1, '{13'd0,    7'd36,  3'd2, 1'b0}},
    '{13'd0,    7'd35,  1'b0, 1'b1, '{13'd0,    7'd35,  3'd1, 1'b0}},
    '{13'd0,    7'd6,   1'b0, 1'b1, '{13'd0,    7'd6,   3'd1, 1'b0}},
    '{13'd0,    7'd5,   1'b1, 1'b1, '{13'd0,    7'd5,   3'd0, 1'b1}},
    '{13'd3450, 7'd100, 1'b0, 1'b1, '{13'd3450, 7'd0,   3'd0, 1'b0}},
    '{13'd0,    7'd77,  1'b1, 1'b1, '{13'd3450, 7'd0,   3'd0, 1'b1}},
    '{13'd3450, 7'd127, 1'b0, 1'b1, '{13'd3450, 7'd0,   3'd0, 1'b0}},
    '{13'd8191, 7'd0,   1'b0, 1'b0, '0},
    '{13'd1,    7'd50,  1'b1, 1'b0, '0},
    '{13'd4200, 7'd0,   1'b0, 1'b0, '0},
    '{13'd4200, 7'd0,   1'b1, 1'b0, '0},
    '{13'd4200, 7'd0,   1'b0, 1'b0, '0},
    '{13'd4200, 7'd0,   1'b0, 1'b0, '0},
    '{13'd4200, 7'd0,   1'b1, 1'b1, '{13'd4200, 7'd100, 3'd4, 1'b1}},
    '{13'd3725, 7'd42,  1'b0, 1'b0, '0},
    '{13'd4096, 7'd64,  1'b1, 1'b0, '0},
    '{13'd2730, 7'd85,  1'b0, 1'b0, '0},
    '{13'd5461, 7'd127, 1'b1, 1'b0, '0}
  };

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  mv_t   sample_mv;
  pct_t  fallback_percent;
  logic  charger_present;
  logic  out_valid;
  logic  out_ready = 1'b0;
  mv_t   avg_mv;
  pct_t  level_percent;
  icon_t icon_level;
  logic  charging;

  reading_t    pending_readings [$];
  mv_t         avg_window [AVG_DEPTH];
  int unsigned avg_fill = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 8;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned phase_left = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  logic        choppy = 1'b0;

  battery_voltage_fuel_gauge_core dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample_mv        (sample_mv),
    .fallback_percent (fallback_percent),
    .charger_present  (charger_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .avg_mv           (avg_mv),
    .level_percent    (level_percent),
    .icon_level       (icon_level),
    .charging         (charging)
  );

  always #6 clk = ~clk;

  function automatic pct_t lipo_soc(int unsigned mv);
    int unsigned seg;
    if (mv >= LIPO_MV[CURVE_POINTS-1]) return PCT_MAX;
    if (mv <= LIPO_MV[0]) return '0;
    for (seg = 1; seg < CURVE_POINTS; seg++) begin
      if (mv < LIPO_MV[seg]) begin
        return pct_t'(CURVE_SOC[seg-1] + (mv - LIPO_MV[seg-1]) *
                      (CURVE_SOC[seg] - CURVE_SOC[seg-1]) / (LIPO_MV[seg] - LIPO_MV[seg-1]));
      end
    end
    return PCT_MAX;
  endfunction

  function automatic icon_t soc_icon(pct_t pct);
    if (pct > ICON_T4) return icon_t'(4);
    if (pct > ICON_T3) return icon_t'(3);
    if (pct > ICON_T2) return icon_t'(2);
    if (pct > ICON_T1) return icon_t'(1);
    return icon_t'(0);
  endfunction

  function automatic reading_t predict_reading(mv_t mv, pct_t fb, logic chg);
    reading_t    r;
    int unsigned sum;
    int unsigned mean;
    int unsigned k;
    sum = 0;
    mean = 0;
    if (mv != '0) begin
      if (avg_fill < AVG_DEPTH) begin
        avg_window[avg_fill] = mv;
        avg_fill++;
      end else begin
        for (k = 1; k < AVG_DEPTH; k++) avg_window[k-1] = avg_window[k];
        avg_window[AVG_DEPTH-1] = mv;
      end
    end
    for (k = 0; k < avg_fill; k++) sum += avg_window[k];
    if (avg_fill != 0) mean = sum / avg_fill;
    r.mv = mv_t'(mean);
    if (mean != 0) r.pct = lipo_soc(mean);
    else r.pct = (fb > PCT_MAX) ? PCT_MAX : fb;
    r.icon = soc_icon(r.pct);
    r.chg = chg;
    return r;
  endfunction

  task automatic offer_reading(mv_t mv, pct_t fb, logic chg, logic typed, reading_t want);
    reading_t predicted;
    in_valid <= 1'b1;
    sample_mv <= mv;
    fallback_percent <= fb;
    charger_present <= chg;
    do @(posedge clk); while (!in_ready);
    predicted = predict_reading(mv, fb, chg);
    pending_readings.push_back(typed ? want : predicted);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("avg_mv: expected no transaction, got %0d", avg_mv);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("avg_mv", 16'(want.mv), 16'(avg_mv));
        check_field("level_percent", 16'(want.pct), 16'(level_percent));
        check_field("icon_level", 16'(want.icon), 16'(icon_level));
        check_field("charging", 16'(want.chg), 16'(charging));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        choppy = ($urandom_range(0, 2) != 0);
        phase_left = $urandom_range(10, 150);
      end
      phase_left--;
      out_ready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    mv_t         mv;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample_mv <= '0;
    fallback_percent <= '0;
    charger_present <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (n = 0; n < PROBE_COUNT; n++) begin
      offer_reading(PROBES[n].mv, PROBES[n].fb, PROBES[n].chg, PROBES[n].typed, PROBES[n].want);
    end
    for (n = 0; n < RANDOM_READINGS; n++) begin
      if (n == RANDOM_READINGS / 3) hold_armed <= 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        mv = '0;
      end else if (pick < 70) begin
        mv = mv_t'($urandom_range(3400, 4250));
      end else if (pick < 85) begin
        mv = mv_t'(int'(LIPO_MV[$urandom_range(0, CURVE_POINTS - 1)]) +
                   int'($urandom_range(0, 4)) - 2);
      end else begin
        mv = mv_t'($urandom_range(1, 8191));
      end
      offer_reading(mv, pct_t'($urandom_range(0, 127)), logic'($urandom_range(0, 1)), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
